/* sv/dark_low_saturation_pixel_mask_macros.svh */
// assertion macros for the dark low-saturation pixel mask
`ifndef DARK_LOW_SATURATION_PIXEL_MASK_MACROS_SVH
`define DARK_LOW_SATURATION_PIXEL_MASK_MACROS_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle as the trigger
`define DLSM_ASSERT_IMPL(label, clock, reset, trig, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
    else $error("dlsm assertion failed");

// condition holds in the cycle after the trigger
`define DLSM_ASSERT_NEXT(label, clock, reset, trig, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
    else $error("dlsm assertion failed");

`else

`define DLSM_ASSERT_IMPL(label, clock, reset, trig, cond)
`define DLSM_ASSERT_NEXT(label, clock, reset, trig, cond)

`endif

`endif

/* sv/dlsm_pkg.sv */
// shared types and constants for the dark low-saturation pixel mask
`default_nettype none

package dlsm_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned ProdW = 17;   // 510*255 and 255*511 both fit

  localparam logic [PixW-1:0] FullScale = 8'hFF;

  typedef enum logic [0:0] {
    REG_SAT_LIMIT = 1'b0,
    REG_INV_LIMIT = 1'b1
  } reg_index_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

/* sv/dlsm_datapath.sv */
// three-stage datapath: min/max, products, threshold compare
`default_nettype none

module dlsm_datapath (
  input  wire logic                    clk,
  input  wire dlsm_pkg::pipe_ctrl_t    ctrl,
  input  wire logic [dlsm_pkg::PixW-1:0] blue,
  input  wire logic [dlsm_pkg::PixW-1:0] green,
  input  wire logic [dlsm_pkg::PixW-1:0] red,
  input  wire logic [dlsm_pkg::PixW-1:0] sat_limit,
  input  wire logic [dlsm_pkg::PixW-1:0] inv_limit,
  output logic [dlsm_pkg::PixW-1:0]      saturation_mask,
  output logic [dlsm_pkg::PixW-1:0]      dark_level,
  output logic [dlsm_pkg::PixW-1:0]      cluster_level
);

  // stage 1
  logic [dlsm_pkg::PixW-1:0] hi_next, lo_next;
  logic [dlsm_pkg::PixW-1:0] s1_v, s1_d;

  // stage 2
  logic [dlsm_pkg::ProdW-1:0] lhs_next, rhs_next;
  logic [dlsm_pkg::PixW-1:0]  inv_next, dark_next;
  logic [dlsm_pkg::ProdW-1:0] s2_lhs, s2_rhs;
  logic                       s2_vzero;
  logic [dlsm_pkg::PixW-1:0]  s2_dark;

  // stage 3
  logic [dlsm_pkg::PixW-1:0] mask_next;

  always_comb begin
    hi_next = blue;
    lo_next = blue;
    if (green > hi_next) hi_next = green;
    if (red > hi_next) hi_next = red;
    if (green < lo_next) lo_next = green;
    if (red < lo_next) lo_next = red;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      s1_v <= hi_next;
      s1_d <= hi_next - lo_next;
    end
  end

  // round(255*d/v) <= L  is  510*d < v*(2L+1)
  always_comb begin
    lhs_next = ({s1_d, 9'b0} - {8'b0, s1_d, 1'b0});
    rhs_next = {9'b0, s1_v} * {8'b0, sat_limit, 1'b1};
    inv_next = dlsm_pkg::FullScale - s1_v;
    dark_next = (inv_next > inv_limit) ? inv_next : '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      s2_lhs   <= lhs_next;
      s2_rhs   <= rhs_next;
      s2_vzero <= (s1_v == '0);
      s2_dark  <= dark_next;
    end
  end

  // black pixel has zero saturation and always passes
  assign mask_next = (s2_vzero || (s2_lhs < s2_rhs)) ? dlsm_pkg::FullScale : '0;

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      saturation_mask <= mask_next;
      dark_level      <= s2_dark;
      cluster_level   <= s2_dark & mask_next;
    end
  end

endmodule

`default_nettype wire

/* sv/dark_low_saturation_pixel_mask.sv */
// Dark low-saturation pixel mask, top level.
//
// Input channel: one pixel (blue, green, red) per transfer on in_valid/in_stall.
// Output channel: saturation_mask, dark_level, cluster_level per transfer on
// out_valid/out_stall, one result per pixel, in order.
// Configuration: wr_en with wr_index 0 writes the saturation limit, index 1 the
// inverted-value limit; write only while no pixel is in flight.
// Pipeline: an accepted pixel is registered in stage 1, then in stage 2, then
// in stage 3, and out_valid is the stage 3 valid bit.
// With the receiver never stalling, one pixel is taken every cycle; the
// three register stages (min/max, 8x9 multiply, compare) each hold one pixel
// and pass it on every cycle.
// When the receiver stalls, the last stage holds its result steady and the
// earlier stages keep filling bubbles; in_stall rises only once every stage
// holds a pixel.
// Reset clears the pipeline valid bits and both limits to zero.
`default_nettype none

`include "dark_low_saturation_pixel_mask_macros.svh"

module dark_low_saturation_pixel_mask (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [dlsm_pkg::PixW-1:0] blue,
  input  wire logic [dlsm_pkg::PixW-1:0] green,
  input  wire logic [dlsm_pkg::PixW-1:0] red,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [dlsm_pkg::PixW-1:0]      saturation_mask,
  output logic [dlsm_pkg::PixW-1:0]      dark_level,
  output logic [dlsm_pkg::PixW-1:0]      cluster_level,
  input  wire logic                      wr_en,
  input  wire logic [0:0]                wr_index,
  input  wire logic [dlsm_pkg::PixW-1:0] wr_data
);

  logic [dlsm_pkg::PixW-1:0] sat_limit, inv_limit;
  logic                      v1, v2, v3;
  dlsm_pkg::pipe_ctrl_t      ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_limit <= '0;
      inv_limit <= '0;
    end else if (wr_en) begin
      case (dlsm_pkg::reg_index_t'(wr_index))
        dlsm_pkg::REG_SAT_LIMIT: sat_limit <= wr_data;
        dlsm_pkg::REG_INV_LIMIT: inv_limit <= wr_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ctrl.en3 = !v3 || !out_stall;
    ctrl.en2 = !v2 || ctrl.en3;
    ctrl.en1 = !v1 || ctrl.en2;
  end

  assign in_stall  = !ctrl.en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ctrl.en1) v1 <= in_valid;
      if (ctrl.en2) v2 <= v1;
      if (ctrl.en3) v3 <= v2;
    end
  end

  dlsm_datapath u_datapath (
    .clk             (clk),
    .ctrl            (ctrl),
    .blue            (blue),
    .green           (green),
    .red             (red),
    .sat_limit       (sat_limit),
    .inv_limit       (inv_limit),
    .saturation_mask (saturation_mask),
    .dark_level      (dark_level),
    .cluster_level   (cluster_level)
  );

  `DLSM_ASSERT_NEXT(a_accept_loads, clk, rst, in_valid && !in_stall, v1)
  `DLSM_ASSERT_IMPL(a_full_stalls, clk, rst, v1 && v2 && v3 && out_stall, in_stall)
  `DLSM_ASSERT_IMPL(a_mask_code, clk, rst, out_valid,
    saturation_mask == dlsm_pkg::FullScale || saturation_mask == '0)
  `DLSM_ASSERT_IMPL(a_cluster_and, clk, rst, out_valid,
    cluster_level == (dark_level & saturation_mask))

endmodule

`default_nettype wire
